// ===== hw/rtl/msm_pkg.sv =====
package msm_pkg;

  // Field widths
  localparam int unsigned SpeedW    = 16;               // input and wheel output fields
  localparam int unsigned LimitW    = 15;               // configuration limits
  localparam int unsigned WheelW    = SpeedW + 2;       // sum of three clamped terms
  localparam int unsigned MagW      = WheelW - 1;       // magnitude of a wheel sum
  localparam int unsigned ProdW     = MagW + LimitW;    // magnitude times wheel limit
  localparam int unsigned QuotW     = LimitW;           // scaled magnitude stays below 2^15
  localparam int unsigned NumWheels = 4;
  localparam int unsigned CfgIdxW   = 2;

  localparam int unsigned DefQueueDepth = 4;

  localparam logic [LimitW-1:0] LimitReset = 15'd8000;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgForward  = 2'd0,
    CfgSideways = 2'd1,
    CfgRotation = 2'd2,
    CfgWheel    = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [LimitW-1:0] fwd;
    logic [LimitW-1:0] side;
    logic [LimitW-1:0] rot;
    logic [LimitW-1:0] wheel;
  } limits_t;

  // Four mixed, unscaled wheel sums (two's complement)
  typedef struct packed {
    logic [NumWheels-1:0][WheelW-1:0] w;
  } wheel_set_t;

endpackage

// ===== hw/rtl/msm_front.sv =====
module msm_front (
  input  logic signed [msm_pkg::SpeedW-1:0] forward_speed_i,
  input  logic signed [msm_pkg::SpeedW-1:0] sideways_speed_i,
  input  logic signed [msm_pkg::SpeedW-1:0] rotation_speed_i,
  input  msm_pkg::limits_t                  limits_i,
  output msm_pkg::wheel_set_t               wheels_o
);

  // Symmetric clamp of one component to +/- lim
  function automatic logic signed [msm_pkg::SpeedW-1:0] clamp_sym(
    input logic signed [msm_pkg::SpeedW-1:0] v,
    input logic        [msm_pkg::LimitW-1:0] lim
  );
    logic signed [msm_pkg::SpeedW:0] v_x;
    logic signed [msm_pkg::SpeedW:0] hi;
    logic signed [msm_pkg::SpeedW:0] lo;
    logic signed [msm_pkg::SpeedW:0] res;
    v_x = (msm_pkg::SpeedW + 1)'(v);
    hi  = $signed({{(msm_pkg::SpeedW + 1 - msm_pkg::LimitW){1'b0}}, lim});
    lo  = -hi;
    if (v_x > hi) begin
      res = hi;
    end else if (v_x < lo) begin
      res = lo;
    end else begin
      res = v_x;
    end
    return res[msm_pkg::SpeedW-1:0];
  endfunction

  logic signed [msm_pkg::SpeedW-1:0] vx, vy, vw;
  logic signed [msm_pkg::WheelW-1:0] vx_x, vy_x, vw_x;

  assign vx = clamp_sym(forward_speed_i,  limits_i.fwd);
  assign vy = clamp_sym(sideways_speed_i, limits_i.side);
  assign vw = clamp_sym(rotation_speed_i, limits_i.rot);

  assign vx_x = msm_pkg::WheelW'(vx);
  assign vy_x = msm_pkg::WheelW'(vy);
  assign vw_x = msm_pkg::WheelW'(vw);

  // Mecanum mix, kept wide so nothing wraps
  always_comb begin
    wheels_o.w[0] = -vy_x - vx_x + vw_x;
    wheels_o.w[1] =  vy_x - vx_x + vw_x;
    wheels_o.w[2] =  vy_x + vx_x + vw_x;
    wheels_o.w[3] = -vy_x + vx_x + vw_x;
  end

endmodule

// ===== hw/rtl/msm_queue.sv =====
module msm_queue #(
  parameter int unsigned Depth = msm_pkg::DefQueueDepth  // at least 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  msm_pkg::wheel_set_t data_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                valid_o,
  output msm_pkg::wheel_set_t data_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  msm_pkg::wheel_set_t mem_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]     cnt_q;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      unique case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== hw/rtl/msm_back.sv =====
module msm_back (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          q_valid_i,
  input  msm_pkg::wheel_set_t                           q_data_i,
  output logic                                          q_pop_o,
  input  logic [msm_pkg::LimitW-1:0]                    wheel_limit_i,
  output logic                                          out_valid_o,
  input  logic                                          out_stall_i,
  output logic [msm_pkg::NumWheels-1:0][msm_pkg::SpeedW-1:0] wheel_o,
  output logic                                          scaled_o
);

  localparam int unsigned NW = msm_pkg::NumWheels;
  localparam int unsigned QW = msm_pkg::QuotW;

  // Whole pipeline moves together unless the output item is held
  logic adv;
  logic out_vld_q;
  assign adv     = !out_vld_q || !out_stall_i;
  assign q_pop_o = adv && q_valid_i;

  // Peak stage: magnitudes, signs, peak, scale decision
  logic [NW-1:0][msm_pkg::MagW-1:0] mag;
  logic [NW-1:0]                    neg;
  logic [msm_pkg::MagW-1:0]         peak;
  logic [msm_pkg::WheelW-1:0]       abs_full [NW];

  always_comb begin
    peak = '0;
    for (int l = 0; l < NW; l++) begin
      neg[l]      = q_data_i.w[l][msm_pkg::WheelW-1];
      abs_full[l] = neg[l] ? -q_data_i.w[l] : q_data_i.w[l];
      mag[l]      = abs_full[l][msm_pkg::MagW-1:0];
      if (mag[l] > peak) begin
        peak = mag[l];
      end
    end
  end

  logic                             pk_vld_q;
  logic [NW-1:0][msm_pkg::MagW-1:0] pk_mag_q;
  logic [NW-1:0]                    pk_neg_q;
  logic [msm_pkg::MagW-1:0]         pk_peak_q;
  logic                             pk_scl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pk_vld_q <= 1'b0;
    end else if (adv) begin
      pk_vld_q <= q_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pk_mag_q  <= mag;
      pk_neg_q  <= neg;
      pk_peak_q <= peak;
      pk_scl_q  <= (peak > msm_pkg::MagW'(wheel_limit_i));
    end
  end

  // Divider pipeline registers; stage 0 is loaded by the multiply stage
  logic                              vld_q [QW+1];
  logic [NW-1:0][msm_pkg::ProdW-1:0] rem_q [QW+1];
  logic [NW-1:0][QW-1:0]             quo_q [QW+1];
  logic [NW-1:0]                     neg_q [QW+1];
  logic [msm_pkg::MagW-1:0]          div_q [QW+1];
  logic                              scl_q [QW+1];

  // Multiply stage: scaled items divide mag*limit by peak, others divide mag by one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (adv) begin
      vld_q[0] <= pk_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int l = 0; l < NW; l++) begin
        rem_q[0][l] <= pk_scl_q ? msm_pkg::ProdW'(pk_mag_q[l] * wheel_limit_i)
                                : msm_pkg::ProdW'(pk_mag_q[l]);
      end
      quo_q[0] <= '0;
      neg_q[0] <= pk_neg_q;
      div_q[0] <= pk_scl_q ? pk_peak_q : msm_pkg::MagW'(1);
      scl_q[0] <= pk_scl_q;
    end
  end

  // Restoring division, one quotient bit per stage, MSB first
  for (genvar s = 0; s < QW; s++) begin : g_div
    localparam int unsigned Bit = QW - 1 - s;

    logic [msm_pkg::ProdW-1:0]         trial;
    logic [NW-1:0][msm_pkg::ProdW-1:0] rem_d;
    logic [NW-1:0][QW-1:0]             quo_d;

    always_comb begin
      trial = msm_pkg::ProdW'(div_q[s]) << Bit;
      for (int l = 0; l < NW; l++) begin
        rem_d[l] = rem_q[s][l];
        quo_d[l] = quo_q[s][l];
        if (rem_q[s][l] >= trial) begin
          rem_d[l]      = rem_q[s][l] - trial;
          quo_d[l][Bit] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s+1] <= 1'b0;
      end else if (adv) begin
        vld_q[s+1] <= vld_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        rem_q[s+1] <= rem_d;
        quo_q[s+1] <= quo_d;
        neg_q[s+1] <= neg_q[s];
        div_q[s+1] <= div_q[s];
        scl_q[s+1] <= scl_q[s];
      end
    end
  end

  // Output register: restore signs
  logic [NW-1:0][msm_pkg::SpeedW-1:0] wheel_d;
  logic [NW-1:0][msm_pkg::SpeedW-1:0] wheel_q;
  logic                               scl_out_q;

  always_comb begin
    for (int l = 0; l < NW; l++) begin
      wheel_d[l] = neg_q[QW][l] ? -msm_pkg::SpeedW'(quo_q[QW][l])
                                :  msm_pkg::SpeedW'(quo_q[QW][l]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= vld_q[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      wheel_q   <= wheel_d;
      scl_out_q <= scl_q[QW];
    end
  end

  assign out_valid_o = out_vld_q;
  assign wheel_o     = wheel_q;
  assign scaled_o    = scl_out_q;

endmodule

// ===== hw/rtl/mecanum_wheel_speed_mixer.sv =====
// Mecanum wheel speed mixer. Each command (forward, sideways, rotation) is
// clamped to its limit, mixed into four wheel sums and, when the largest wheel
// magnitude is above wheel_limit, every wheel is scaled by wheel_limit / peak
// with truncation toward zero; was_scaled_o flags that case. One item is
// accepted per cycle while in_stall_o is low, and one result leaves per cycle
// while out_stall_i is low. The item is written into the input queue at
// acceptance, its peak is taken straight from the queue head into the peak
// stage, then come a multiply stage, a 15-stage pipelined divider and the
// output register. A queue of QueueDepth items decouples the front from the
// back; in_stall_o rises only when that queue is full. Limits must be written
// while no item is in flight.
module mecanum_wheel_speed_mixer #(
  parameter int unsigned QueueDepth = msm_pkg::DefQueueDepth
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Configuration writes
  input  logic                               cfg_we_i,
  input  logic [msm_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [msm_pkg::LimitW-1:0]         cfg_wdata_i,
  // Command channel
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [msm_pkg::SpeedW-1:0]  forward_speed_i,
  input  logic signed [msm_pkg::SpeedW-1:0]  sideways_speed_i,
  input  logic signed [msm_pkg::SpeedW-1:0]  rotation_speed_i,
  // Wheel channel
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [msm_pkg::SpeedW-1:0]  wheel0_speed_o,
  output logic signed [msm_pkg::SpeedW-1:0]  wheel1_speed_o,
  output logic signed [msm_pkg::SpeedW-1:0]  wheel2_speed_o,
  output logic signed [msm_pkg::SpeedW-1:0]  wheel3_speed_o,
  output logic                               was_scaled_o
);

  // Limit registers
  msm_pkg::limits_t limits_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limits_q.fwd   <= msm_pkg::LimitReset;
      limits_q.side  <= msm_pkg::LimitReset;
      limits_q.rot   <= msm_pkg::LimitReset;
      limits_q.wheel <= msm_pkg::LimitReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        msm_pkg::CfgForward:  limits_q.fwd   <= cfg_wdata_i;
        msm_pkg::CfgSideways: limits_q.side  <= cfg_wdata_i;
        msm_pkg::CfgRotation: limits_q.rot   <= cfg_wdata_i;
        msm_pkg::CfgWheel:    limits_q.wheel <= cfg_wdata_i;
        default:              limits_q       <= limits_q;
      endcase
    end
  end

  // Front: clamp and mix
  msm_pkg::wheel_set_t front_wheels;

  msm_front u_front (
    .forward_speed_i  (forward_speed_i),
    .sideways_speed_i (sideways_speed_i),
    .rotation_speed_i (rotation_speed_i),
    .limits_i         (limits_q),
    .wheels_o         (front_wheels)
  );

  // Queue between front and back
  logic                q_full, q_valid, q_pop, q_push;
  msm_pkg::wheel_set_t q_data;

  assign q_push     = in_valid_i && !q_full;
  assign in_stall_o = q_full;

  msm_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (front_wheels),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_data)
  );

  // Back: peak, scale and divide
  logic [msm_pkg::NumWheels-1:0][msm_pkg::SpeedW-1:0] wheels;

  msm_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_data_i      (q_data),
    .q_pop_o       (q_pop),
    .wheel_limit_i (limits_q.wheel),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .wheel_o       (wheels),
    .scaled_o      (was_scaled_o)
  );

  assign wheel0_speed_o = $signed(wheels[0]);
  assign wheel1_speed_o = $signed(wheels[1]);
  assign wheel2_speed_o = $signed(wheels[2]);
  assign wheel3_speed_o = $signed(wheels[3]);

endmodule

// ===== hw/rtl/msm_checker.sv =====
module msm_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_stall_o,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic signed [msm_pkg::SpeedW-1:0] wheel0_speed_o,
  input logic signed [msm_pkg::SpeedW-1:0] wheel1_speed_o,
  input logic signed [msm_pkg::SpeedW-1:0] wheel2_speed_o,
  input logic signed [msm_pkg::SpeedW-1:0] wheel3_speed_o,
  input logic                              was_scaled_o
);

  // Opposite wheel pairs both sum to twice the rotation term when unscaled
  logic signed [msm_pkg::SpeedW:0] sum_02, sum_13;
  assign sum_02 = (msm_pkg::SpeedW + 1)'(wheel0_speed_o) + (msm_pkg::SpeedW + 1)'(wheel2_speed_o);
  assign sum_13 = (msm_pkg::SpeedW + 1)'(wheel1_speed_o) + (msm_pkg::SpeedW + 1)'(wheel3_speed_o);

  a_out_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result item dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(wheel0_speed_o) && $stable(wheel1_speed_o)
      && $stable(wheel2_speed_o) && $stable(wheel3_speed_o) && $stable(was_scaled_o))
    else $error("stalled result item changed");

  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o && !in_stall_o)
    else $error("pipeline not empty after reset");

  a_unscaled_mix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !was_scaled_o |-> sum_02 == sum_13)
    else $error("unscaled wheel pairs disagree on rotation term");

endmodule

bind mecanum_wheel_speed_mixer msm_checker u_msm_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .wheel0_speed_o (wheel0_speed_o),
  .wheel1_speed_o (wheel1_speed_o),
  .wheel2_speed_o (wheel2_speed_o),
  .wheel3_speed_o (wheel3_speed_o),
  .was_scaled_o   (was_scaled_o)
);
